[rtl/core/rgnm_pkg.sv]
// Shared types and constants for the regular grammar NFA matcher.
// Used by the cells, the interface users and the top level.
package rgnm_pkg;

    localparam int SYM_W = 8;
    localparam int NT_W  = 5;

    typedef enum logic [1:0] {
        OP_RULE  = 2'd0,
        OP_SYM   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [SYM_W-1:0] symbol;
        logic [NT_W-1:0]  from_nonterminal;
        logic [NT_W-1:0]  to_target;
        logic             last;
    } t_item;

    typedef struct packed {
        logic accepted;
    } t_result;

    typedef struct packed {
        logic [NT_W-1:0] start_nonterminal;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RULE,
        ST_STEP
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic            clear_wr;
        logic            rule_wr;
        logic [NT_W-1:0] from;
        logic            load_start;
        logic [NT_W-1:0] start;
        logic            start_ok;
        logic            step;
        logic            sym_ok;
    } t_cell_ctl;

endpackage

[rtl/core/rgnm_if.sv]
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is set at instantiation; no other dependencies.
interface rgnm_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/regular_grammar_nfa_matcher.sv]
// Top level: sequencer, configuration register and the chain of cells.
// Depends on rgnm_pkg, rgnm_if and rgnm_cell.
//
//  channel    dir  payload                                       beat
//  i_item     in   op, symbol, from_nonterminal, to_target, last  one rule/symbol/clear
//  o_result   out  accepted                                       one per last symbol
//  i_cfg      in   start_nonterminal                              one register write
//
// Rule and symbol beats read every cell row in the idle state, then do the
// read-modify-write or the OR across the cell chain. Op 3 stays in idle.
// Reset and every clear beat start a clearing pass over all SYMBOLS
// cell rows; no item beat is taken during it, config writes are.
// A last symbol waits in its step only while the output register holds an untaken beat.
module regular_grammar_nfa_matcher #(
    parameter int NONTERMINALS = 26,
    parameter int SYMBOLS      = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rgnm_if.sink   i_item,
    rgnm_if.source o_result,
    rgnm_if.sink   i_cfg
);
    import rgnm_pkg::*;

    localparam int SET_W = NONTERMINALS + 1;
    localparam int AW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_cnt;
    logic            r_in_word;
    logic            r_out_valid;
    logic            r_accepted;
    logic [NT_W-1:0] r_start;
    logic [AW-1:0]   r_addr;
    logic [NT_W-1:0] r_from;
    logic [SET_W-1:0] r_tmask;
    logic            r_rule_ok;
    logic            r_sym_ok;
    logic            r_last;

    t_cell_ctl        w_ctl;
    logic             w_in_ready;
    logic             w_acc;
    logic [AW-1:0]    w_addr;
    logic [SET_W-1:0] w_chain [NONTERMINALS+1];
    logic [SET_W-1:0] w_union;
    logic [NONTERMINALS-1:0] w_active;

    assign w_acc   = i_item.valid && w_in_ready;
    assign w_union = w_chain[NONTERMINALS];
    assign w_chain[0] = '0;

    always_comb begin
        unique case (r_state)
            ST_CLEAR: w_addr = r_cnt;
            ST_IDLE:  w_addr = i_item.data.symbol[AW-1:0];
            default:  w_addr = r_addr;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        w_in_ready       = 1'b0;
        w_ctl.clear_wr   = 1'b0;
        w_ctl.rule_wr    = 1'b0;
        w_ctl.from       = r_from;
        w_ctl.load_start = 1'b0;
        w_ctl.start      = r_start;
        w_ctl.start_ok   = int'(r_start) < NONTERMINALS;
        w_ctl.step       = 1'b0;
        w_ctl.sym_ok     = r_sym_ok;
        unique case (r_state)
            ST_CLEAR: begin
                w_ctl.clear_wr = 1'b1;
                if (r_cnt == AW'(SYMBOLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_item.valid) begin
                    unique case (i_item.data.op)
                        OP_RULE:  n_state = ST_RULE;
                        OP_SYM: begin
                            n_state          = ST_STEP;
                            w_ctl.load_start = !r_in_word;
                        end
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RULE: begin
                w_ctl.rule_wr = r_rule_ok;
                n_state       = ST_IDLE;
            end
            ST_STEP: begin
                if (!r_last || !r_out_valid || o_result.ready) begin
                    w_ctl.step = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_in_word   <= 1'b0;
            r_out_valid <= 1'b0;
            r_start     <= '0;
        end else begin
            r_cnt <= (r_state == ST_CLEAR) ? r_cnt + AW'(1) : '0;

            if (w_acc && i_item.data.op == OP_CLEAR) begin
                r_in_word <= 1'b0;
            end else if (w_ctl.load_start) begin
                r_in_word <= 1'b1;
            end else if (w_ctl.step && r_last) begin
                r_in_word <= 1'b0;
            end

            if (w_ctl.step && r_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid) begin
                r_start <= i_cfg.data.start_nonterminal;
            end
        end
    end

    // Beat payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_addr    <= i_item.data.symbol[AW-1:0];
            r_from    <= i_item.data.from_nonterminal;
            r_tmask   <= SET_W'(1) << i_item.data.to_target;
            r_rule_ok <= (int'(i_item.data.from_nonterminal) < NONTERMINALS)
                      && (int'(i_item.data.symbol) < SYMBOLS)
                      && (int'(i_item.data.to_target) <= NONTERMINALS);
            r_sym_ok  <= int'(i_item.data.symbol) < SYMBOLS;
            r_last    <= i_item.data.last;
        end
        if (w_ctl.step && r_last) begin
            r_accepted <= w_union[NONTERMINALS];
        end
    end

    for (genvar g = 0; g < NONTERMINALS; g++) begin : g_cell
        rgnm_cell #(
            .IDX   (g),
            .SET_W (SET_W),
            .DEPTH (SYMBOLS),
            .AW    (AW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_addr        (w_addr),
            .i_tmask       (r_tmask),
            .i_union       (w_chain[g]),
            .i_next_active (w_union[g]),
            .o_union       (w_chain[g+1]),
            .o_active      (w_active[g])
        );
    end

    assign i_item.ready           = w_in_ready;
    assign i_cfg.ready            = 1'b1;
    assign o_result.valid         = r_out_valid;
    assign o_result.data.accepted = r_accepted;

    a_clear_drops_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_item.data.op == OP_CLEAR) |=> (!r_in_word && r_state == ST_CLEAR))
        else $error("clear beat did not abandon word");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_STEP && $past(r_last)))
        else $error("result raised outside a last symbol step");

    a_word_start_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_item.data.op == OP_SYM && !r_in_word) |=> $onehot0(w_active))
        else $error("word start loaded more than one active cell");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!w_ctl.clear_wr && !w_ctl.rule_wr))
        else $error("cell row written while idle");

endmodule

[rtl/core/rgnm_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module rgnm_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/rgnm_cell.sv]
// One nonterminal cell: its row of the rule table and its active bit.
// Depends on rgnm_pkg and rgnm_ram; ORs its targets into the chain.
module rgnm_cell #(
    parameter int IDX   = 0,
    parameter int SET_W = 27,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgnm_pkg::t_cell_ctl i_ctl,
    input  logic [AW-1:0]       i_addr,
    input  logic [SET_W-1:0]    i_tmask,
    input  logic [SET_W-1:0]    i_union,
    input  logic                i_next_active,
    output logic [SET_W-1:0]    o_union,
    output logic                o_active
);
    import rgnm_pkg::*;

    logic             r_active;
    logic             w_sel;
    logic             w_we;
    logic [SET_W-1:0] w_wdata;
    logic [SET_W-1:0] w_rdata;

    assign w_sel   = (int'(i_ctl.from) == IDX);
    assign w_we    = i_ctl.clear_wr || (i_ctl.rule_wr && w_sel);
    assign w_wdata = i_ctl.clear_wr ? '0 : (w_rdata | i_tmask);

    rgnm_ram #(
        .WIDTH (SET_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_row (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (i_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_ctl.clear_wr) begin
            r_active <= 1'b0;
        end else if (i_ctl.load_start) begin
            r_active <= i_ctl.start_ok && (int'(i_ctl.start) == IDX);
        end else if (i_ctl.step) begin
            r_active <= i_next_active;
        end
    end

    assign o_union  = i_union | ((r_active && i_ctl.sym_ok) ? w_rdata : '0);
    assign o_active = r_active;
endmodule
